// ===== rtl/krt_pkg.sv =====
// ----------------------------------------------------------------------------
// krt_pkg
// Shared types and constants of the keyed rating table: field widths, table
// word layout, register indexes and the structs passed between modules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package krt_pkg;

    // field widths
    localparam int KEY_W    = 32;
    localparam int RATING_W = 23;
    localparam int NEW_W    = 24;

    // table word: key, first rating, second rating
    localparam int WORD_W    = KEY_W + 2 * RATING_W;
    localparam int KEY_MSB   = WORD_W - 1;
    localparam int KEY_LSB   = 2 * RATING_W;
    localparam int FIRST_MSB = 2 * RATING_W - 1;
    localparam int FIRST_LSB = RATING_W;
    localparam int SECOND_MSB = RATING_W - 1;

    // configuration port
    localparam int APB_ADDR_W = 4;
    localparam int APB_DATA_W = 32;
    localparam int REG_IDX_W  = 2;

    typedef enum logic [REG_IDX_W-1:0] {
        REG_LO_LIMIT    = 2'd0,
        REG_HI_LIMIT    = 2'd1,
        REG_MISS_RATING = 2'd2,
        REG_NONE        = 2'd3
    } reg_idx_t;

    localparam logic [RATING_W-1:0] LO_LIMIT_RST    = 23'd256;
    localparam logic [RATING_W-1:0] HI_LIMIT_RST    = 23'd8388607;
    localparam logic [RATING_W-1:0] MISS_RATING_RST = 23'd256;

    // request codes
    localparam logic REQ_READ  = 1'b0;
    localparam logic REQ_WRITE = 1'b1;

    // register values seen by the core
    typedef struct packed {
        logic [RATING_W-1:0] lo_limit;
        logic [RATING_W-1:0] hi_limit;
        logic [RATING_W-1:0] miss_rating;
    } cfg_t;

    // lookup outcome; done marks the end of a search, the rest is held until the next search finishes
    typedef struct packed {
        logic                done;
        logic                hit;
        logic [RATING_W-1:0] first;
        logic [RATING_W-1:0] second;
    } scan_res_t;

endpackage

`default_nettype wire

// ===== rtl/krt_req_if.sv =====
// ----------------------------------------------------------------------------
// krt_req_if
// Request channel: valid/ready handshake carrying one request word.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface krt_req_if;
    logic                                 valid;
    logic                                 ready;
    logic                                 req_type;
    logic signed [krt_pkg::KEY_W-1:0]     profile_key;
    logic                                 which_rating;
    logic signed [krt_pkg::NEW_W-1:0]     new_rating;

    modport source (
        output valid, req_type, profile_key, which_rating, new_rating,
        input  ready
    );

    modport sink (
        input  valid, req_type, profile_key, which_rating, new_rating,
        output ready
    );
endinterface

`default_nettype wire

// ===== rtl/krt_rsp_if.sv =====
// ----------------------------------------------------------------------------
// krt_rsp_if
// Response channel: valid/ready handshake carrying one result word.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface krt_rsp_if;
    logic                            valid;
    logic                            ready;
    logic [krt_pkg::RATING_W-1:0]    rating_out;
    logic                            hit;
    logic                            done_res;

    modport source (
        output valid, rating_out, hit, done_res,
        input  ready
    );

    modport sink (
        input  valid, rating_out, hit, done_res,
        output ready
    );
endinterface

`default_nettype wire

// ===== rtl/krt_ram.sv =====
// ----------------------------------------------------------------------------
// krt_ram
// Generic simple dual-port RAM: one write port, one read port with a
// registered read.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module krt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// ===== rtl/krt_apb_regs.sv =====
// ----------------------------------------------------------------------------
// krt_apb_regs
// APB-style register block holding the clamp limits and the default rating.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module krt_apb_regs (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              psel,
    input  wire logic                              penable,
    input  wire logic                              pwrite,
    input  wire logic [krt_pkg::APB_ADDR_W-1:0]    paddr,
    input  wire logic [krt_pkg::APB_DATA_W-1:0]    pwdata,
    output logic      [krt_pkg::APB_DATA_W-1:0]    prdata,
    output logic                                   pready,
    output krt_pkg::cfg_t                          cfg
);

    logic [krt_pkg::RATING_W-1:0] min_reg;
    logic [krt_pkg::RATING_W-1:0] max_reg;
    logic [krt_pkg::RATING_W-1:0] dflt_reg;
    krt_pkg::reg_idx_t            idx;
    logic                         wr_en;
    logic [krt_pkg::RATING_W-1:0] rd_val;

    assign idx    = krt_pkg::reg_idx_t'(paddr[krt_pkg::APB_ADDR_W-1:2]);
    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;

    // register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_reg  <= krt_pkg::LO_LIMIT_RST;
            max_reg  <= krt_pkg::HI_LIMIT_RST;
            dflt_reg <= krt_pkg::MISS_RATING_RST;
        end
        else if (wr_en)
        begin
            unique case (idx)
                krt_pkg::REG_LO_LIMIT:    min_reg  <= pwdata[krt_pkg::RATING_W-1:0];
                krt_pkg::REG_HI_LIMIT:    max_reg  <= pwdata[krt_pkg::RATING_W-1:0];
                krt_pkg::REG_MISS_RATING: dflt_reg <= pwdata[krt_pkg::RATING_W-1:0];
                default:                  ;
            endcase
        end
    end

    // read mux
    always_comb
    begin
        unique case (idx)
            krt_pkg::REG_LO_LIMIT:    rd_val = min_reg;
            krt_pkg::REG_HI_LIMIT:    rd_val = max_reg;
            krt_pkg::REG_MISS_RATING: rd_val = dflt_reg;
            default:                  rd_val = '0;
        endcase
    end

    assign prdata = {{(krt_pkg::APB_DATA_W - krt_pkg::RATING_W){1'b0}}, rd_val};

    assign cfg.lo_limit    = min_reg;
    assign cfg.hi_limit    = max_reg;
    assign cfg.miss_rating = dflt_reg;

endmodule

`default_nettype wire

// ===== rtl/krt_scan.sv =====
// ----------------------------------------------------------------------------
// krt_scan
// Lookup engine: walks the filled part of the table memory one address per
// cycle and stops at the first entry whose key matches.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module krt_scan #(
    parameter int TABLE_ENTRIES = 128
) (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 start,
    input  wire logic [krt_pkg::KEY_W-1:0]            key,
    input  wire logic [$clog2(TABLE_ENTRIES+1)-1:0]   fill,
    output logic                                      re,
    output logic      [$clog2(TABLE_ENTRIES)-1:0]     raddr,
    input  wire logic [krt_pkg::WORD_W-1:0]           rdata,
    output krt_pkg::scan_res_t                        res,
    output logic      [$clog2(TABLE_ENTRIES)-1:0]     res_idx
);

    localparam int IDX_W = $clog2(TABLE_ENTRIES);
    localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);

    logic                         busy_reg;
    logic                         busy_next;
    logic [CNT_W-1:0]             addr_reg;
    logic [CNT_W-1:0]             addr_next;
    logic                         pend_reg;
    logic                         pend_next;
    logic [IDX_W-1:0]             pend_idx_reg;
    logic                         done_reg;
    logic                         done_next;
    logic                         hit_reg;
    logic [IDX_W-1:0]             idx_reg;
    logic [krt_pkg::RATING_W-1:0] first_reg;
    logic [krt_pkg::RATING_W-1:0] second_reg;
    logic                         match;
    logic                         finish;

    // issue reads while inside the filled range
    assign re    = busy_reg && (addr_reg < fill);
    assign raddr = addr_reg[IDX_W-1:0];

    // compare the word read in the previous cycle
    assign match  = busy_reg && pend_reg &&
                    (rdata[krt_pkg::KEY_MSB:krt_pkg::KEY_LSB] == key);
    assign finish = match || (busy_reg && (addr_reg == fill));

    always_comb
    begin
        busy_next = busy_reg;
        addr_next = addr_reg;
        pend_next = pend_reg;
        done_next = 1'b0;
        if (start)
        begin
            busy_next = 1'b1;
            addr_next = '0;
            pend_next = 1'b0;
        end
        else if (finish)
        begin
            busy_next = 1'b0;
            pend_next = 1'b0;
            done_next = 1'b1;
        end
        else if (busy_reg)
        begin
            pend_next = re;
            addr_next = addr_reg + CNT_W'(re);
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            addr_reg <= '0;
            pend_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            addr_reg <= addr_next;
            pend_reg <= pend_next;
            done_reg <= done_next;
        end
    end

    // outcome and the address of the word in flight
    always_ff @(posedge clk)
    begin
        if (busy_reg)
        begin
            pend_idx_reg <= addr_reg[IDX_W-1:0];
        end
        if (finish)
        begin
            hit_reg    <= match;
            idx_reg    <= pend_idx_reg;
            first_reg  <= rdata[krt_pkg::FIRST_MSB:krt_pkg::FIRST_LSB];
            second_reg <= rdata[krt_pkg::SECOND_MSB:0];
        end
    end

    assign res.done   = done_reg;
    assign res.hit    = hit_reg;
    assign res.first  = first_reg;
    assign res.second = second_reg;
    assign res_idx    = idx_reg;

endmodule

`default_nettype wire

// ===== rtl/keyed_rating_table_round_robin_unit.sv =====
// ----------------------------------------------------------------------------
// keyed_rating_table_round_robin_unit
// Fully associative rating table with first-free allocation and round-robin
// replacement, held in one table memory read, modified and written back.
// ----------------------------------------------------------------------------
// flow: a positive key is searched through the occupied entries up to the
//   first match; a non-positive key skips the search and goes to the result
// throughput: one request at a time; the next is accepted only after the
//   previous result has been placed in the output register
// reset: count, victim pointer and registers reset at once; entries past the
//   count are never read, so the table memory needs no clearing pass
`timescale 1ns / 1ps
`default_nettype none

module keyed_rating_table_round_robin_unit #(
    parameter int TABLE_ENTRIES = 128
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              psel,
    input  wire logic                              penable,
    input  wire logic                              pwrite,
    input  wire logic [krt_pkg::APB_ADDR_W-1:0]    paddr,
    input  wire logic [krt_pkg::APB_DATA_W-1:0]    pwdata,
    output logic      [krt_pkg::APB_DATA_W-1:0]    prdata,
    output logic                                   pready,
    krt_req_if.sink                                req,
    krt_rsp_if.source                              rsp
);

    localparam int IDX_W = $clog2(TABLE_ENTRIES);
    localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);
    localparam logic [CNT_W-1:0] FULL_CNT  = CNT_W'(TABLE_ENTRIES);
    localparam logic [IDX_W-1:0] LAST_IDX  = IDX_W'(TABLE_ENTRIES - 1);

    typedef enum logic [2:0] {
        S_IDLE   = 3'b001,
        S_SCAN   = 3'b010,
        S_FINISH = 3'b100
    } state_t;

    state_t                        state_reg;
    state_t                        state_next;
    krt_pkg::cfg_t                 cfg;
    krt_pkg::scan_res_t            scan_res;
    logic [IDX_W-1:0]              scan_idx;
    logic                          ram_re;
    logic [IDX_W-1:0]              ram_raddr;
    logic [krt_pkg::WORD_W-1:0]    ram_rdata;
    logic                          ram_we;
    logic [IDX_W-1:0]              ram_waddr;
    logic [krt_pkg::WORD_W-1:0]    ram_wdata;

    // request word held for the whole lookup
    logic                          type_reg;
    logic [krt_pkg::KEY_W-1:0]     key_reg;
    logic                          which_reg;
    logic signed [krt_pkg::NEW_W-1:0] new_reg;
    logic                          bad_reg;
    logic                          start_reg;
    logic                          start_next;

    logic [CNT_W-1:0]              fill_reg;
    logic [CNT_W-1:0]              fill_next;
    logic [IDX_W-1:0]              victim_reg;
    logic [IDX_W-1:0]              victim_next;

    logic                          out_valid_reg;
    logic                          out_valid_next;
    logic [krt_pkg::RATING_W-1:0]  out_rating_reg;
    logic                          out_hit_reg;
    logic                          out_done_reg;

    logic                          accept;
    logic                          key_bad;
    logic                          fire;
    logic                          hit;
    logic                          do_write;
    logic                          full;
    logic                          alloc_free;
    logic                          evict;
    logic [krt_pkg::RATING_W-1:0]  clamped;
    logic [krt_pkg::RATING_W-1:0]  old_first;
    logic [krt_pkg::RATING_W-1:0]  old_second;
    logic [krt_pkg::RATING_W-1:0]  rating;

    // configuration registers
    krt_apb_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // table memory, word = key, first rating, second rating
    krt_ram #(
        .WIDTH (krt_pkg::WORD_W),
        .DEPTH (TABLE_ENTRIES)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // lookup engine; reads and the write-back never overlap in time
    krt_scan #(
        .TABLE_ENTRIES (TABLE_ENTRIES)
    ) u_scan (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start_reg),
        .key     (key_reg),
        .fill    (fill_reg),
        .re      (ram_re),
        .raddr   (ram_raddr),
        .rdata   (ram_rdata),
        .res     (scan_res),
        .res_idx (scan_idx)
    );

    // input handshake
    assign req.ready = (state_reg == S_IDLE);
    assign accept    = req.valid && req.ready;
    assign key_bad   = req.profile_key[krt_pkg::KEY_W-1] || (req.profile_key == '0);

    // decision for the held request
    assign hit        = !bad_reg && scan_res.hit;
    assign do_write   = !bad_reg && (type_reg == krt_pkg::REQ_WRITE);
    assign full       = (fill_reg == FULL_CNT);
    assign alloc_free = do_write && !hit && !full;
    assign evict      = do_write && !hit && full;
    assign fire       = (state_reg == S_FINISH) && (!out_valid_reg || rsp.ready);

    // clamp: below min first, then above max
    always_comb
    begin
        priority if (new_reg < $signed({1'b0, cfg.lo_limit}))
        begin
            clamped = cfg.lo_limit;
        end
        else if (new_reg > $signed({1'b0, cfg.hi_limit}))
        begin
            clamped = cfg.hi_limit;
        end
        else
        begin
            clamped = new_reg[krt_pkg::RATING_W-1:0];
        end
    end

    // new or evicted entries start with both ratings at zero
    assign old_first  = hit ? scan_res.first  : '0;
    assign old_second = hit ? scan_res.second : '0;

    // result rating
    always_comb
    begin
        priority if (bad_reg)
        begin
            rating = (type_reg == krt_pkg::REQ_WRITE) ? '0 : cfg.miss_rating;
        end
        else if (do_write)
        begin
            rating = clamped;
        end
        else if (hit)
        begin
            rating = which_reg ? scan_res.second : scan_res.first;
        end
        else
        begin
            rating = cfg.miss_rating;
        end
    end

    // write-back
    assign ram_we    = fire && do_write;
    assign ram_waddr = hit ? scan_idx : (full ? victim_reg : fill_reg[IDX_W-1:0]);
    assign ram_wdata = {key_reg,
                        which_reg ? old_first : clamped,
                        which_reg ? clamped   : old_second};

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        start_next = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if (key_bad)
                    begin
                        state_next = S_FINISH;
                    end
                    else
                    begin
                        state_next = S_SCAN;
                        start_next = 1'b1;
                    end
                end
            end
            S_SCAN:
            begin
                if (scan_res.done)
                begin
                    state_next = S_FINISH;
                end
            end
            S_FINISH:
            begin
                if (fire)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // occupancy and replacement pointer
    always_comb
    begin
        fill_next   = fill_reg;
        victim_next = victim_reg;
        if (fire && alloc_free)
        begin
            fill_next = fill_reg + CNT_W'(1);
        end
        if (fire && evict)
        begin
            victim_next = (victim_reg == LAST_IDX) ? '0 : victim_reg + IDX_W'(1);
        end
    end

    // output word register
    assign out_valid_next = fire ? 1'b1 : (rsp.ready ? 1'b0 : out_valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            start_reg     <= 1'b0;
            fill_reg      <= '0;
            victim_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            start_reg     <= start_next;
            fill_reg      <= fill_next;
            victim_reg    <= victim_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // request and result payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            type_reg  <= req.req_type;
            key_reg   <= req.profile_key;
            which_reg <= req.which_rating;
            new_reg   <= req.new_rating;
            bad_reg   <= key_bad;
        end
        if (fire)
        begin
            out_rating_reg <= rating;
            out_hit_reg    <= hit;
            out_done_reg   <= do_write;
        end
    end

    assign rsp.valid      = out_valid_reg;
    assign rsp.rating_out = out_rating_reg;
    assign rsp.hit        = out_hit_reg;
    assign rsp.done_res   = out_done_reg;

endmodule

`default_nettype wire
